FILE: rtl/core/cpsg_pkg.sv
// ----------------------------------------------------------------------------
// cpsg_pkg
// Shared types and constants of the path segment geometry block: payload
// structs, configuration register map and fixed-point formats.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsg_pkg;

    // Fixed-point formats.
    localparam int SINE_INDEX_BITS = 10;  // address bits of the full-turn sine table
    localparam int COORD_FRAC_BITS = 12;  // fraction bits of the coordinates

    localparam int ANGLE_W = 16;
    localparam int SINE_W  = 16;
    localparam int COORD_W = 32;
    localparam int LEN_W   = 24;
    localparam int PIX_W   = 8;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_ODD   = 3'd0,
        CFG_ANGLE_EVEN  = 3'd1,
        CFG_LINE_LENGTH = 3'd2,
        CFG_LINE_WIDTH  = 3'd3,
        CFG_LOGARITHMIC = 3'd4
    } cpsg_cfg_idx_t;

    localparam logic [PIX_W-1:0] LINE_LENGTH_RESET = 8'd10;
    localparam logic [PIX_W-1:0] LINE_WIDTH_RESET  = 8'd1;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_odd;
        logic [ANGLE_W-1:0] angle_even;
        logic [PIX_W-1:0]   line_length;
        logic [PIX_W-1:0]   line_width;
        logic               logarithmic;
    } cpsg_cfg_t;

    typedef struct packed {
        logic is_odd;
        logic first_of_sequence;
    } cpsg_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_side_x;
        logic signed [COORD_W-1:0] start_side_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_side_y;
        logic signed [COORD_W-1:0] start_side_y;
    } cpsg_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/cpsg_sine.sv
// ----------------------------------------------------------------------------
// cpsg_sine
// Q1.15 sine of a 16-bit binary angle. The table holds one quarter wave and
// the other quadrants are mirrored and negated from it.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsg_sine (
    input  wire logic        [cpsg_pkg::ANGLE_W-1:0] angle,
    output      logic signed [cpsg_pkg::SINE_W-1:0]  sine
);
    import cpsg_pkg::*;

    localparam int QW          = SINE_INDEX_BITS - 2;
    localparam int QTAB_DEPTH  = 1 << QW;
    localparam int SINE_SHIFT  = ANGLE_W - SINE_INDEX_BITS;
    localparam int MAG_W       = SINE_W - 1;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned ONE_Q30    = 64'd1073741824;

    typedef logic [MAG_W-1:0] qtab_t [QTAB_DEPTH];

    // Magnitude of the sine of a first-quadrant angle (0 to a quarter turn),
    // from a Q30 Taylor series in Horner form, rounded to Q15.
    function automatic logic [MAG_W-1:0] sine_mag(input longint unsigned a);
        longint unsigned r;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        r  = (a * TWO_PI_Q30) >> 16;
        x2 = (r * r) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s  = (r * t) >> 30;
        v  = (s + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return MAG_W'(v);
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t q;
        for (int k = 0; k < QTAB_DEPTH; k++) begin
            q[k] = sine_mag(longint'(k) << SINE_SHIFT);
        end
        return q;
    endfunction

    localparam qtab_t            QTAB = build_qtab();
    localparam logic [MAG_W-1:0] PEAK = sine_mag(longint'(QUARTER_TURN));

    logic [SINE_INDEX_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [QW-1:0]              low;
    logic [QW-1:0]              addr;
    logic [MAG_W-1:0]           mag;
    logic signed [SINE_W-1:0]   mag_s;

    always_comb begin
        idx  = angle[ANGLE_W-1 -: SINE_INDEX_BITS];
        quad = idx[SINE_INDEX_BITS-1 -: 2];
        low  = idx[QW-1:0];
        // Odd quadrants run the table backward; their first entry is the peak.
        addr = quad[0] ? QW'(~low + QW'(1)) : low;
        if (quad[0] && (low == '0)) begin
            mag = PEAK;
        end else begin
            mag = QTAB[addr];
        end
        mag_s = signed'({1'b0, mag});
        sine  = quad[1] ? -mag_s : mag_s;
    end

endmodule

`default_nettype wire

FILE: rtl/core/cpsg_datapath.sv
// ----------------------------------------------------------------------------
// cpsg_datapath
// Turtle state (position, heading, length) and the combinational segment
// computation: heading step, sine and cosine lookup, offset multiplies and
// saturating coordinate sums.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsg_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire cpsg_pkg::cpsg_in_t  item,
    input  wire cpsg_pkg::cpsg_cfg_t cfg,
    output      cpsg_pkg::cpsg_out_t result
);
    import cpsg_pkg::*;

    localparam int PROD_W      = LEN_W + SINE_W + 1;
    localparam int SCALE_SHIFT = 31 - COORD_FRAC_BITS;
    localparam int OFF_W       = PROD_W - SCALE_SHIFT;
    localparam int SUM_W       = COORD_W + 1;
    localparam int DECAY_W     = LEN_W + 16;

    localparam logic [15:0] DECAY_Q16 = 16'd64881;

    // Length or width (Q8.16) times a Q1.15 value, rounded half up to the
    // coordinate format.
    function automatic logic signed [OFF_W-1:0] scale_q16(
        input logic        [LEN_W-1:0]  mag,
        input logic signed [SINE_W-1:0] s
    );
        logic signed [LEN_W:0]    m;
        logic signed [PROD_W-1:0] prod;
        m    = signed'({1'b0, mag});
        prod = PROD_W'(m) * PROD_W'(s);
        prod = prod + (PROD_W'(1) <<< (SCALE_SHIFT - 1));
        return OFF_W'(prod >>> SCALE_SHIFT);
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] a,
        input logic signed [OFF_W-1:0]   b
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s[SUM_W-1] != s[SUM_W-2]) begin
            return s[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return s[COORD_W-1:0];
    endfunction

    logic signed [COORD_W-1:0] pos_x_reg, pos_y_reg;
    logic        [ANGLE_W-1:0] heading_reg;
    logic        [LEN_W-1:0]   length_reg;

    logic signed [COORD_W-1:0] base_x, base_y;
    logic        [ANGLE_W-1:0] base_heading, theta, cos_angle;
    logic        [LEN_W-1:0]   base_len, width_q16, length_next;
    logic signed [SINE_W-1:0]  sin_v, cos_v, neg_sin;
    logic signed [OFF_W-1:0]   dx, dy, wx, wy;
    logic signed [COORD_W-1:0] ex, ey;
    logic        [DECAY_W-1:0] decay_prod;

    always_comb begin
        if (item.first_of_sequence) begin
            base_x       = '0;
            base_y       = '0;
            base_heading = QUARTER_TURN;
            base_len     = {cfg.line_length, 16'h0000};
        end else begin
            base_x       = pos_x_reg;
            base_y       = pos_y_reg;
            base_heading = heading_reg;
            base_len     = length_reg;
        end
        theta     = base_heading + (item.is_odd ? cfg.angle_odd : cfg.angle_even);
        cos_angle = theta + QUARTER_TURN;
        width_q16 = {cfg.line_width, 16'h0000};
    end

    cpsg_sine u_sin (
        .angle (theta),
        .sine  (sin_v)
    );

    cpsg_sine u_cos (
        .angle (cos_angle),
        .sine  (cos_v)
    );

    always_comb begin
        // The side direction is a quarter turn on: its cosine is minus the
        // sine and its sine is the cosine, exactly, by table symmetry.
        neg_sin = -sin_v;
        dx = scale_q16(base_len, cos_v);
        dy = scale_q16(base_len, sin_v);
        wx = scale_q16(width_q16, neg_sin);
        wy = scale_q16(width_q16, cos_v);

        ex = sat_add(base_x, dx);
        ey = sat_add(base_y, dy);

        result.start_x      = base_x;
        result.end_x        = ex;
        result.end_side_x   = sat_add(ex, wx);
        result.start_side_x = sat_add(base_x, wx);
        result.start_y      = base_y;
        result.end_y        = ey;
        result.end_side_y   = sat_add(ey, wy);
        result.start_side_y = sat_add(base_y, wy);

        decay_prod  = DECAY_W'(base_len) * DECAY_W'(DECAY_Q16) + DECAY_W'(32768);
        length_next = cfg.logarithmic ? decay_prod[DECAY_W-1:16] : base_len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= QUARTER_TURN;
            length_reg  <= {LINE_LENGTH_RESET, 16'h0000};
        end else if (step) begin
            pos_x_reg   <= ex;
            pos_y_reg   <= ey;
            heading_reg <= theta;
            length_reg  <= length_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/collatz_path_segment_geometry.sv
// ----------------------------------------------------------------------------
// collatz_path_segment_geometry
// Turtle path generator: one quad of segment geometry per parity item.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one item per step of a sequence walked from 1
//   toward N: its parity and a flag that restarts the path at the origin,
//   heading ninety degrees, with the configured length.
//   m_valid/m_ready return one item per input item: start, end and the two
//   side points offset by the line width, as signed Q20.12 coordinates.
//   The cfg_wr_* port writes a register when cfg_wr_en is high;
//   unknown indexes are ignored. Write only while the block is idle.
// Pipeline and throughput:
//   An accepted item is registered in the input stage, processed there
//   and stored in the result register that drives m_data; a stall holds it
//   in the input stage. One item per cycle is sustained while m_ready stays
//   high. The heading add, the sine table lookup, the offset multiply and the
//   saturating sum feed the position and heading registers of the next item.
// Reset and stalls:
//   Reset clears both stages, restores the register defaults and the turtle
//   state. While m_ready is low the result holds and the input stage fills;
//   s_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module collatz_path_segment_geometry (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [cpsg_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  wire logic [cpsg_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire cpsg_pkg::cpsg_in_t                  s_data,
    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      cpsg_pkg::cpsg_out_t                 m_data
);
    import cpsg_pkg::*;

    cpsg_cfg_t cfg_reg;
    logic      in_valid_reg;
    cpsg_in_t  in_data_reg;
    logic      out_valid_reg;
    cpsg_out_t out_data_reg;
    cpsg_out_t result;
    logic      advance;
    logic      step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.angle_odd   <= '0;
            cfg_reg.angle_even  <= '0;
            cfg_reg.line_length <= LINE_LENGTH_RESET;
            cfg_reg.line_width  <= LINE_WIDTH_RESET;
            cfg_reg.logarithmic <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_ANGLE_ODD:   cfg_reg.angle_odd   <= cfg_wr_data[ANGLE_W-1:0];
                CFG_ANGLE_EVEN:  cfg_reg.angle_even  <= cfg_wr_data[ANGLE_W-1:0];
                CFG_LINE_LENGTH: cfg_reg.line_length <= cfg_wr_data[PIX_W-1:0];
                CFG_LINE_WIDTH:  cfg_reg.line_width  <= cfg_wr_data[PIX_W-1:0];
                CFG_LOGARITHMIC: cfg_reg.logarithmic <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipe moves when the result register is empty or being taken.
    assign advance = !out_valid_reg || m_ready;
    assign step    = advance && in_valid_reg;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= result;
        end
    end

    cpsg_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

    a_ready_low_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a full, blocked pipeline");

    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    a_stall_keeps_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("pending item lost during a stall");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the path segment geometry block. A scoreboard
// class keeps its own turtle state, sine table and register copy, predicts
// one quad per accepted parity item and compares every coordinate of each
// returned item. Stimulus covers a directed set, two long straight runs far
// from the origin and random phases built mostly from reversed Collatz
// sequences, with bursty input and a patterned, stalling receiver.
// ----------------------------------------------------------------------------

module tb;
    import cpsg_pkg::*;

    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_NS     = 5_000_000;
    localparam int RUN_STEPS      = 280;
    localparam int RANDOM_PHASES  = 7;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_RESULT = 300;
    localparam int CFG_SLOTS      = 1 << CFG_IDX_W;
    localparam int ROM_DEPTH      = 1 << SINE_INDEX_BITS;
    localparam int OFFSET_SHIFT   = 31 - COORD_FRAC_BITS;

    localparam longint unsigned DECAY_Q16  = 64'd64881;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned ONE_Q30    = 64'd1 << 30;
    localparam longint COORD_MAX = (longint'(1) <<< 31) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< 31);

    class segment_geometry_board;
        logic [ANGLE_W-1:0]        angle_odd;
        logic [ANGLE_W-1:0]        angle_even;
        logic [PIX_W-1:0]          length_px;
        logic [PIX_W-1:0]          width_px;
        logic                      log_mode;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [ANGLE_W-1:0]        heading;
        logic [LEN_W-1:0]          cur_length;
        int                        sine_rom [ROM_DEPTH];
        cpsg_out_t                 pending_quads [$];
        int                        mismatches;

        function void restart_path();
            pos_x      = '0;
            pos_y      = '0;
            heading    = QUARTER_TURN;
            cur_length = {length_px, 16'h0000};
        endfunction

        // Quadrant-folded Taylor series in Q30, rounded to Q15.
        function int sine_q15(logic [ANGLE_W-1:0] angle);
            longint unsigned a, r, x2, t, s, v;
            a = angle[13:0];
            if (angle[14]) begin
                a = QUARTER_TURN - a;
            end
            r  = (a * TWO_PI_Q30) >> 16;
            x2 = (r * r) >> 30;
            t  = ONE_Q30;
            for (int k = 5; k >= 1; k--) begin
                t = ONE_Q30 - ((x2 * t) >> 30) / (2 * k * (2 * k + 1));
            end
            s = (r * t) >> 30;
            v = (s + (64'd1 << 14)) >> 15;
            if (v > 32767) begin
                v = 32767;
            end
            return angle[15] ? -int'(v) : int'(v);
        endfunction

        function new();
            angle_odd  = '0;
            angle_even = '0;
            length_px  = LINE_LENGTH_RESET;
            width_px   = LINE_WIDTH_RESET;
            log_mode   = 1'b0;
            mismatches = 0;
            for (int i = 0; i < ROM_DEPTH; i++) begin
                sine_rom[i] = sine_q15(ANGLE_W'(i << (ANGLE_W - SINE_INDEX_BITS)));
            end
            restart_path();
        endfunction

        function int sine_at(logic [ANGLE_W-1:0] angle);
            return sine_rom[angle[ANGLE_W-1 -: SINE_INDEX_BITS]];
        endfunction

        // Q8.16 magnitude times Q1.15 sine, rounded half up to coordinate format.
        function longint scaled(longint unsigned mag, int s);
            longint prod;
            prod = longint'(mag) * longint'(s);
            return (prod + (longint'(1) <<< (OFFSET_SHIFT - 1))) >>> OFFSET_SHIFT;
        endfunction

        function logic signed [COORD_W-1:0] sat_sum(longint a, longint b);
            longint s;
            s = a + b;
            if (s > COORD_MAX) begin
                s = COORD_MAX;
            end else if (s < COORD_MIN) begin
                s = COORD_MIN;
            end
            return s[COORD_W-1:0];
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ANGLE_ODD:   angle_odd  = data[ANGLE_W-1:0];
                CFG_ANGLE_EVEN:  angle_even = data[ANGLE_W-1:0];
                CFG_LINE_LENGTH: length_px  = data[PIX_W-1:0];
                CFG_LINE_WIDTH:  width_px   = data[PIX_W-1:0];
                CFG_LOGARITHMIC: log_mode   = data[0];
                default: ;
            endcase
        endfunction

        function void note_item(cpsg_in_t item);
            logic [ANGLE_W-1:0]        theta, side, back;
            logic signed [COORD_W-1:0] ex, ey;
            longint unsigned           width_q16;
            longint                    dx, dy, wx, wy;
            cpsg_out_t                 quad;
            if (item.first_of_sequence) begin
                restart_path();
            end
            theta     = heading + (item.is_odd ? angle_odd : angle_even);
            side      = theta + QUARTER_TURN;
            back      = side + QUARTER_TURN;
            width_q16 = 64'(width_px) << 16;
            // The cosine of an angle is the sine a quarter turn further on.
            dx = scaled(cur_length, sine_at(side));
            dy = scaled(cur_length, sine_at(theta));
            wx = scaled(width_q16, sine_at(back));
            wy = scaled(width_q16, sine_at(side));
            ex = sat_sum(pos_x, dx);
            ey = sat_sum(pos_y, dy);
            quad.start_x      = pos_x;
            quad.end_x        = ex;
            quad.end_side_x   = sat_sum(ex, wx);
            quad.start_side_x = sat_sum(pos_x, wx);
            quad.start_y      = pos_y;
            quad.end_y        = ey;
            quad.end_side_y   = sat_sum(ey, wy);
            quad.start_side_y = sat_sum(pos_y, wy);
            pending_quads = {pending_quads, quad};
            pos_x   = ex;
            pos_y   = ey;
            heading = theta;
            if (log_mode) begin
                cur_length = LEN_W'((64'(cur_length) * DECAY_Q16 + 64'd32768) >> 16);
            end
        endfunction

        function void compare_coord(string name, logic signed [COORD_W-1:0] want,
                                    logic signed [COORD_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_quad(cpsg_out_t got);
            cpsg_out_t want;
            if (pending_quads.size() == 0) begin
                $error("result item arrived with no quad expected");
                mismatches++;
                return;
            end
            want = pending_quads.pop_front();
            compare_coord("start_x", want.start_x, got.start_x);
            compare_coord("end_x", want.end_x, got.end_x);
            compare_coord("end_side_x", want.end_side_x, got.end_side_x);
            compare_coord("start_side_x", want.start_side_x, got.start_side_x);
            compare_coord("start_y", want.start_y, got.start_y);
            compare_coord("end_y", want.end_y, got.end_y);
            compare_coord("end_side_y", want.end_side_y, got.end_side_y);
            compare_coord("start_side_y", want.start_side_y, got.start_side_y);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    cpsg_in_t              s_data       = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    cpsg_out_t             m_data;

    segment_geometry_board board;
    int burst_left    = 0;
    bit steady_sender = 1'b0;
    int items_sent    = 0;
    int results_seen  = 0;

    collatz_path_segment_geometry u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF_NS aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        board.set_reg(idx, data);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] odd_step, even_step,
                                input logic [CFG_DATA_W-1:0] len, wid, logm);
        put_reg(CFG_ANGLE_ODD, odd_step);
        put_reg(CFG_ANGLE_EVEN, even_step);
        put_reg(CFG_LINE_LENGTH, len);
        put_reg(CFG_LINE_WIDTH, wid);
        put_reg(CFG_LOGARITHMIC, logm);
        // A write to an unmapped index must leave every register alone.
        put_reg(CFG_IDX_W'($urandom_range(int'(CFG_LOGARITHMIC) + 1, CFG_SLOTS - 1)),
                CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(input logic odd, input logic first);
        cpsg_in_t item;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady_sender) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        burst_left--;
        item.is_odd            = odd;
        item.first_of_sequence = first;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(item);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending_quads.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Parities of the sequence from 1 up toward n, n itself left out.
    task automatic send_collatz(input int unsigned n, input bit with_first);
        bit          parity [$];
        int unsigned v;
        v = n;
        while (v != 1) begin
            v = v[0] ? 3 * v + 1 : v / 2;
            parity.push_front(v[0]);
        end
        foreach (parity[i]) begin
            send_item(parity[i], with_first && (i == 0));
        end
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_item(1'($urandom), $urandom_range(0, 7) == 0);
    endtask

    // Field value in the low bits, favoring the extremes; upper bits are junk.
    function automatic logic [CFG_DATA_W-1:0] pick_value(input int bits);
        logic [CFG_DATA_W-1:0] mask, raw, v;
        mask = CFG_DATA_W'((1 << bits) - 1);
        raw  = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 3))
            0: v = '0;
            1: v = '1;
            default: v = CFG_DATA_W'($urandom);
        endcase
        return (raw & ~mask) | (v & mask);
    endfunction

    task automatic random_phase(input int quota);
        int start;
        program_regs(pick_value(ANGLE_W), pick_value(ANGLE_W), pick_value(PIX_W),
                     pick_value(PIX_W), pick_value(1));
        steady_sender = ($urandom_range(0, 3) == 0);
        start = items_sent;
        while (items_sent - start < quota) begin
            case ($urandom_range(0, 9))
                0, 1: send_noise($urandom_range(1, 12));
                // Without its first flag the sequence continues the old path.
                2: send_collatz($urandom_range(2, 2000), 1'b0);
                default: send_collatz($urandom_range(2, 2000), 1'b1);
            endcase
        end
        wait_drained();
    endtask

    initial begin : result_sink
        int hold_left = 0;
        int mode      = 0;
        int mode_left = 0;
        int tick      = 0;
        bit held      = 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (aresetn && m_valid && m_ready) begin
                board.check_quad(m_data);
                results_seen++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 160);
            end
            mode_left--;
            // One long hold-off so the block fills and pushes back on its input.
            if (hold_left > 0) begin
                hold_left--;
            end else if (!held && results_seen >= HOLD_AT_RESULT) begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        board = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Path straight from the reset state, no first flag yet.
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        wait_drained();

        // Largest angle, length and width with decay; a restart mid-stream.
        program_regs(16'hFFFF, 16'h0000, 16'h00FF, 16'h00FF, 16'h0001);
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        wait_drained();

        // Quarter turns with zero length and zero width.
        program_regs(QUARTER_TURN, 16'(3 * QUARTER_TURN), 16'h0000, 16'h0000, 16'h0000);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        wait_drained();

        // A new line length mid-sequence only applies from the next first flag.
        program_regs(16'h0400, 16'h8000, 16'hFF80, 16'hFF07, 16'hFFFE);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b0);
        wait_drained();

        // Straight up at full length, a long run away from the origin.
        program_regs(16'h0000, 16'h0000, 16'h00FF, 16'h00FF, 16'h0000);
        send_item(1'($urandom), 1'b1);
        repeat (RUN_STEPS) send_item(1'($urandom), 1'b0);
        wait_drained();

        // Turn once to 180 degrees, then a long run toward negative x.
        program_regs(QUARTER_TURN, 16'h0000, 16'h00FF, 16'h0080, 16'h0000);
        send_item(1'b1, 1'b1);
        wait_drained();
        program_regs(16'h0000, 16'h0000, 16'h00FF, 16'h0080, 16'h0000);
        repeat (RUN_STEPS) send_item(1'($urandom), 1'b0);
        wait_drained();

        repeat (RANDOM_PHASES) random_phase($urandom_range(40, 80));

        if (board.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
